// ----- src/turning_motor_move_guard_core_macros.svh -----
// Assertion helpers for the turning motor move guard.
// Each one samples on aclk and is quiet while aresetn is low.
`ifndef TURNING_MOTOR_MOVE_GUARD_CORE_MACROS_SVH
`define TURNING_MOTOR_MOVE_GUARD_CORE_MACROS_SVH

// Condition must hold whenever the antecedent holds, same cycle.
`define TMMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define TMMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tmmg_pkg.sv -----
package tmmg_pkg;

    // item function codes; codes above FUNC_READ behave as a read
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_STOP    = 3'd2;
    localparam logic [2:0] FUNC_SWITCH  = 3'd3;
    localparam logic [2:0] FUNC_CURRENT = 3'd4;
    localparam logic [2:0] FUNC_READ    = 3'd5;

    // start duration modes; the unused code runs unlimited
    localparam logic [1:0] MODE_UNLIMITED = 2'd0;
    localparam logic [1:0] MODE_SHORT     = 2'd1;
    localparam logic [1:0] MODE_CONFIG    = 2'd2;

    // direction codes, two's complement of -1 / 0 / +1
    localparam logic [1:0] DIR_STOP = 2'b00;
    localparam logic [1:0] DIR_RING = 2'b01;
    localparam logic [1:0] DIR_BAD  = 2'b10;
    localparam logic [1:0] DIR_BURY = 2'b11;

    // configuration register indexes
    localparam logic [1:0] REG_CUR_LIMIT = 2'd0;
    localparam logic [1:0] REG_OC_TIME   = 2'd1;
    localparam logic [1:0] REG_STEP      = 2'd2;

    localparam int CFG_W = 24;

    localparam logic [23:0] CUR_LIMIT_MAX   = 24'd10000000;
    localparam logic [23:0] CUR_LIMIT_RESET = 24'd1500000;
    localparam logic [12:0] OC_TIME_MAX     = 13'd5000;
    localparam logic [12:0] OC_TIME_RESET   = 13'd1000;
    localparam logic [19:0] STEP_MIN        = 20'd1;
    localparam logic [19:0] STEP_MAX        = 20'd999000;
    localparam logic [19:0] STEP_RESET      = 20'd1000;
    localparam logic [19:0] SHORT_MOVE_MS   = 20'd100;
    localparam logic [19:0] CNT_MAX         = 20'hFFFFF;
    localparam logic [7:0]  SWITCH_RESET    = 8'hFF;

    localparam int SW_BURY_BIT = 6;
    localparam int SW_RING_BIT = 7;

    typedef struct packed {
        logic [23:0] current_limit;
        logic [12:0] overcurrent_time;
        logic [19:0] step_duration;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         func;
        logic               direction;
        logic [1:0]         duration_mode;
        logic signed [24:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  dir_state;
        logic        timed_flag;
        logic [19:0] remain_count;
        logic        exc_active;
        logic [19:0] exc_count;
        logic [7:0]  switch_latch;
    } state_t;

    typedef struct packed {
        logic        stopped_now;
        logic        at_ring_end;
        logic        at_bury_end;
        logic [1:0]  cur_position;
        logic [19:0] exc_time_ms;
        logic [19:0] time_left_ms;
        logic signed [1:0] going_dir;
        logic        drive_ring;
        logic        drive_bury;
    } result_t;

endpackage

// ----- src/tmmg_step.sv -----
module tmmg_step
    import tmmg_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic        stopped;
    logic        halt;
    logic [19:0] remain_dec;
    logic [24:0] mag;
    logic        above;
    logic        lb;
    logic        lr;

    always_comb begin
        state_next = state;
        stopped    = 1'b0;
        halt       = 1'b0;
        remain_dec = state.remain_count - 20'd1;
        mag        = item.sample_value[24] ? (~item.sample_value + 25'd1)
                                           : item.sample_value;
        above      = mag > {1'b0, cfg.current_limit};
        lb         = ~item.sample_value[SW_BURY_BIT];
        lr         = ~item.sample_value[SW_RING_BIT];

        unique case (item.func)
            FUNC_TICK: begin
                if (state.timed_flag && (state.remain_count != 20'd0)) begin
                    state_next.remain_count = remain_dec;
                    if (remain_dec == 20'd0) begin
                        halt    = 1'b1;
                        stopped = 1'b1;
                    end
                end
                if (state.exc_active && (state.exc_count != CNT_MAX)) begin
                    state_next.exc_count = state.exc_count + 20'd1;
                end
            end
            FUNC_START: begin
                unique case (item.duration_mode)
                    MODE_SHORT: begin
                        state_next.timed_flag   = 1'b1;
                        state_next.remain_count = SHORT_MOVE_MS;
                    end
                    MODE_CONFIG: begin
                        state_next.timed_flag   = 1'b1;
                        state_next.remain_count = cfg.step_duration;
                    end
                    default: begin
                        state_next.timed_flag   = 1'b0;
                        state_next.remain_count = 20'd0;
                    end
                endcase
                state_next.dir_state = item.direction ? DIR_RING : DIR_BURY;
            end
            FUNC_STOP: begin
                halt    = 1'b1;
                stopped = 1'b1;
            end
            FUNC_SWITCH: begin
                state_next.switch_latch = item.sample_value[7:0];
                if ((lb && state.dir_state == DIR_BURY) ||
                    (lr && state.dir_state == DIR_RING)) begin
                    halt    = 1'b1;
                    stopped = 1'b1;
                end
            end
            FUNC_CURRENT: begin
                if (!state.exc_active) begin
                    if (above) begin
                        state_next.exc_active = 1'b1;
                        state_next.exc_count  = 20'd0;
                    end
                end else if (above) begin
                    // trip keeps the timer, so later samples trip again
                    if (state.exc_count > {7'd0, cfg.overcurrent_time}) begin
                        halt    = 1'b1;
                        stopped = 1'b1;
                    end
                end else begin
                    state_next.exc_active = 1'b0;
                    state_next.exc_count  = 20'd0;
                end
            end
            default: begin
            end
        endcase

        if (halt) begin
            state_next.dir_state    = DIR_STOP;
            state_next.timed_flag   = 1'b0;
            state_next.remain_count = 20'd0;
        end

        result.drive_bury   = state_next.dir_state == DIR_BURY;
        result.drive_ring   = state_next.dir_state == DIR_RING;
        result.going_dir    = state_next.dir_state;
        result.time_left_ms = state_next.timed_flag ? state_next.remain_count : 20'd0;
        result.exc_time_ms  = state_next.exc_active ? state_next.exc_count : 20'd0;
        result.cur_position = state_next.switch_latch[7:6];
        result.at_bury_end  = ~state_next.switch_latch[SW_BURY_BIT];
        result.at_ring_end  = ~state_next.switch_latch[SW_RING_BIT];
        result.stopped_now  = stopped;
    end

endmodule

// ----- src/turning_motor_move_guard_core.sv -----
// An accepted item waits in the input register and its result is registered.
// One item per cycle while the output is not stalled; the input register and
// the result register form a two-stage pipeline, with the state update in stage two.
// Reset (aresetn low at a clock edge): motor stopped, timers cleared, switch
// latch all ones, configuration registers back to their defaults.
`include "turning_motor_move_guard_core_macros.svh"

module turning_motor_move_guard_core
    import tmmg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    // [0] direction, [2:1] duration_mode, [27:3] sample_value, [31:28] zero
    input  logic [31:0]      s_tdata,
    // [2:0] func
    input  logic [2:0]       s_tuser,

    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] drive_bury, [1] drive_ring, [3:2] going_dir, [23:4] time_left_ms,
    // [43:24] exc_time_ms, [45:44] cur_position, [46] at_bury_end,
    // [47] at_ring_end, [48] stopped_now, [55:49] zero
    output logic [55:0]      m_tdata,

    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    // register the item; move it on when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.func          <= s_tuser;
            item_reg.direction     <= s_tdata[0];
            item_reg.duration_mode <= s_tdata[2:1];
            item_reg.sample_value  <= s_tdata[27:3];
        end
    end

    tmmg_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dir_state    <= DIR_STOP;
            state_reg.timed_flag   <= 1'b0;
            state_reg.remain_count <= 20'd0;
            state_reg.exc_active   <= 1'b0;
            state_reg.exc_count    <= 20'd0;
            state_reg.switch_latch <= SWITCH_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg};

    // clamp every write to the register's range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_limit    <= CUR_LIMIT_RESET;
            cfg_reg.overcurrent_time <= OC_TIME_RESET;
            cfg_reg.step_duration    <= STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CUR_LIMIT: begin
                    cfg_reg.current_limit <= (cfg_wdata > CUR_LIMIT_MAX) ? CUR_LIMIT_MAX
                                                                         : cfg_wdata;
                end
                REG_OC_TIME: begin
                    cfg_reg.overcurrent_time <= (cfg_wdata > {11'd0, OC_TIME_MAX})
                                                ? OC_TIME_MAX : cfg_wdata[12:0];
                end
                REG_STEP: begin
                    if (cfg_wdata < {4'd0, STEP_MIN}) begin
                        cfg_reg.step_duration <= STEP_MIN;
                    end else if (cfg_wdata > {4'd0, STEP_MAX}) begin
                        cfg_reg.step_duration <= STEP_MAX;
                    end else begin
                        cfg_reg.step_duration <= cfg_wdata[19:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `TMMG_ASSERT_NOW(a_dir_code, 1'b1, state_reg.dir_state != DIR_BAD, "invalid direction code")
    `TMMG_ASSERT_NOW(a_timed_running, state_reg.timed_flag,
        (state_reg.remain_count != 20'd0) && (state_reg.dir_state != DIR_STOP),
        "timed move without time left or direction")
    `TMMG_ASSERT_NOW(a_exc_idle, !state_reg.exc_active, state_reg.exc_count == 20'd0,
        "overcurrent count set while timer idle")
    `TMMG_ASSERT_NEXT(a_stop_item, advance && (item_reg.func == FUNC_STOP),
        m_tvalid && (state_reg.dir_state == DIR_STOP) && m_tdata[48],
        "stop item did not stop the motor")

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import tmmg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_REPORTS    = 10;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;
    logic [2:0]       s_tuser   = FUNC_READ;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [55:0]      m_tdata;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_addr  = REG_CUR_LIMIT;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // shadow registers and motor state of the predictor
    logic [23:0] shadow_cur_limit;
    logic [12:0] shadow_oc_time;
    logic [19:0] shadow_step;
    logic [1:0]  motor_dir;
    logic        motor_timed;
    logic [19:0] motor_remain;
    logic        motor_exc_on;
    logic [19:0] motor_exc_cnt;
    logic [7:0]  motor_switches;

    result_t pending_status[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    event hold_go;

    int mismatch_cnt = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int stops_seen   = 0;
    int quiet_cycles = 0;

    turning_motor_move_guard_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic item_t make_item(logic [2:0] f, logic d, logic [1:0] m,
                                        logic [24:0] v);
        item_t it;
        it.func          = f;
        it.direction     = d;
        it.duration_mode = m;
        it.sample_value  = v;
        return it;
    endfunction

    function automatic result_t predict_motor(item_t it);
        result_t     r;
        logic [24:0] raw;
        logic [24:0] mag;
        logic        above;
        logic        halt;
        halt = 1'b0;
        raw  = it.sample_value;
        mag  = raw[24] ? (25'd0 - raw) : raw;
        case (it.func)
            FUNC_TICK: begin
                if (motor_timed && motor_remain != 0) begin
                    motor_remain = motor_remain - 20'd1;
                    if (motor_remain == 0) halt = 1'b1;
                end
                if (motor_exc_on && motor_exc_cnt != CNT_MAX)
                    motor_exc_cnt = motor_exc_cnt + 20'd1;
            end
            FUNC_START: begin
                case (it.duration_mode)
                    MODE_SHORT: begin
                        motor_timed  = 1'b1;
                        motor_remain = SHORT_MOVE_MS;
                    end
                    MODE_CONFIG: begin
                        motor_timed  = 1'b1;
                        motor_remain = shadow_step;
                    end
                    default: begin
                        motor_timed  = 1'b0;
                        motor_remain = '0;
                    end
                endcase
                motor_dir = it.direction ? DIR_RING : DIR_BURY;
            end
            FUNC_STOP: halt = 1'b1;
            FUNC_SWITCH: begin
                motor_switches = raw[7:0];
                // stop only when heading into an active (low) limit switch
                if ((!motor_switches[SW_BURY_BIT] && motor_dir == DIR_BURY) ||
                    (!motor_switches[SW_RING_BIT] && motor_dir == DIR_RING))
                    halt = 1'b1;
            end
            FUNC_CURRENT: begin
                above = mag > {1'b0, shadow_cur_limit};
                if (!motor_exc_on) begin
                    if (above) begin
                        motor_exc_on  = 1'b1;
                        motor_exc_cnt = '0;
                    end
                end else if (above) begin
                    // timer keeps running after a trip, so each later sample trips again
                    if (motor_exc_cnt > {7'd0, shadow_oc_time}) halt = 1'b1;
                end else begin
                    motor_exc_on  = 1'b0;
                    motor_exc_cnt = '0;
                end
            end
            default: ;
        endcase
        if (halt) begin
            motor_dir    = DIR_STOP;
            motor_timed  = 1'b0;
            motor_remain = '0;
        end
        r.drive_bury   = (motor_dir == DIR_BURY);
        r.drive_ring   = (motor_dir == DIR_RING);
        r.going_dir    = motor_dir;
        r.time_left_ms = motor_timed ? motor_remain : 20'd0;
        r.exc_time_ms  = motor_exc_on ? motor_exc_cnt : 20'd0;
        r.cur_position = motor_switches[7:6];
        r.at_bury_end  = !motor_switches[SW_BURY_BIT];
        r.at_ring_end  = !motor_switches[SW_RING_BIT];
        r.stopped_now  = halt;
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t       it;
        int          pick;
        int unsigned mag;
        logic        neg;
        logic [24:0] v;
        pick = $urandom_range(99);
        v    = 25'($urandom);
        it   = make_item(FUNC_READ, 1'($urandom_range(1)), 2'($urandom_range(3)), v);
        if (pick < 36)      it.func = FUNC_TICK;
        else if (pick < 50) it.func = FUNC_START;
        else if (pick < 55) it.func = FUNC_STOP;
        else if (pick < 67) it.func = FUNC_SWITCH;
        else if (pick < 88) it.func = FUNC_CURRENT;
        else if (pick < 95) it.func = FUNC_READ;
        else                it.func = 3'($urandom_range(7, 6));
        if (it.func == FUNC_SWITCH) begin
            // limits mostly released so that moves survive
            it.sample_value[SW_BURY_BIT] = ($urandom_range(3) != 0);
            it.sample_value[SW_RING_BIT] = ($urandom_range(3) != 0);
        end else if (it.func == FUNC_CURRENT) begin
            case ($urandom_range(7))
                0, 1, 2: mag = shadow_cur_limit + $urandom_range(1, 3);
                3:       mag = (shadow_cur_limit > 2) ?
                               shadow_cur_limit - $urandom_range(2) : shadow_cur_limit;
                4:       mag = $urandom_range(shadow_cur_limit);
                5:       mag = $urandom_range(16777215, shadow_cur_limit);
                6:       mag = 0;
                default: mag = 16777216;
            endcase
            neg = (mag == 16777216) ? 1'b1 : 1'($urandom_range(1));
            it.sample_value = neg ? (25'd0 - 25'(mag)) : 25'(mag);
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off, counted here so the sender can keep pushing
    initial forever begin
        @(hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin : status_monitor
        item_t   acc;
        result_t exp;
        result_t got;
        if (aresetn && s_tvalid && s_tready) begin
            acc = make_item(s_tuser, s_tdata[0], s_tdata[2:1], s_tdata[27:3]);
            exp = predict_motor(acc);
            pending_status.push_back(exp);
            items_sent++;
            if (exp.stopped_now) stops_seen++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[48:0];
            results_seen++;
            if (pending_status.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result %h", m_tdata);
            end else begin
                exp = pending_status.pop_front();
                if (got.drive_bury !== exp.drive_bury || got.drive_ring !== exp.drive_ring ||
                    got.going_dir !== exp.going_dir || got.time_left_ms !== exp.time_left_ms ||
                    got.exc_time_ms !== exp.exc_time_ms ||
                    got.cur_position !== exp.cur_position ||
                    got.at_bury_end !== exp.at_bury_end ||
                    got.at_ring_end !== exp.at_ring_end ||
                    got.stopped_now !== exp.stopped_now ||
                    m_tdata[55:49] !== 7'd0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("result %0d exp: bury=%0d ring=%0d dir=%0d left=%0d exc=%0d",
                                 results_seen, exp.drive_bury, exp.drive_ring,
                                 exp.going_dir, exp.time_left_ms, exp.exc_time_ms);
                        $display("    pos=%0d lb=%0d lr=%0d stop=%0d",
                                 exp.cur_position, exp.at_bury_end, exp.at_ring_end,
                                 exp.stopped_now);
                        $display("result %0d got: bury=%0d ring=%0d dir=%0d left=%0d exc=%0d",
                                 results_seen, got.drive_bury, got.drive_ring,
                                 got.going_dir, got.time_left_ms, got.exc_time_ms);
                        $display("    pos=%0d lb=%0d lr=%0d stop=%0d pad=%h",
                                 got.cur_position, got.at_bury_end, got.at_ring_end,
                                 got.stopped_now, m_tdata[55:49]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // call at a rising edge; returns at the edge that accepts the item
    task automatic send_command(item_t it);
        int gap;
        gap = 0;
        if (tx_idle_pct > 0)
            while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it.sample_value, it.duration_mode, it.direction};
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CUR_LIMIT: shadow_cur_limit = (val > CUR_LIMIT_MAX) ? CUR_LIMIT_MAX : val;
            REG_OC_TIME:   shadow_oc_time = (val > OC_TIME_MAX) ? OC_TIME_MAX : val[12:0];
            REG_STEP: begin
                if (val < STEP_MIN)      shadow_step = STEP_MIN;
                else if (val > STEP_MAX) shadow_step = STEP_MAX;
                else                     shadow_step = val[19:0];
            end
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic [23:0] cur, logic [23:0] oc, logic [23:0] step);
        write_reg(REG_CUR_LIMIT, cur);
        write_reg(REG_OC_TIME, oc);
        write_reg(REG_STEP, step);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_moves();
        send_command(make_item(FUNC_READ, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(3'd6, 1'b1, MODE_CONFIG, 25'h1FFFFFF));
        send_command(make_item(3'd7, 1'b0, 2'd3, 25'h0AAAAAA));
        send_command(make_item(FUNC_START, 1'b1, MODE_SHORT, 25'd0));
        send_command(make_item(FUNC_TICK, 1'b0, MODE_UNLIMITED, 25'd0));
        // restart while moving replaces the timer
        send_command(make_item(FUNC_START, 1'b0, MODE_CONFIG, 25'd0));
        send_command(make_item(FUNC_START, 1'b1, 2'd3, 25'd0));
        send_command(make_item(FUNC_STOP, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_STOP, 1'b0, MODE_UNLIMITED, 25'd0));
        wait_drained();
    endtask

    task automatic test_limit_switches();
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h00000BF));
        send_command(make_item(FUNC_START, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h00000BF));
        send_command(make_item(FUNC_START, 1'b1, MODE_SHORT, 25'd0));
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h1FFFFBF));
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h000007F));
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h000003F));
        send_command(make_item(FUNC_SWITCH, 1'b0, MODE_UNLIMITED, 25'h00000FF));
        wait_drained();
    endtask

    task automatic test_timed_expiry();
        // a step write of zero lands on the one-millisecond floor
        set_config(CUR_LIMIT_RESET, 24'(OC_TIME_RESET), 24'd0);
        send_command(make_item(FUNC_START, 1'b1, MODE_CONFIG, 25'd0));
        send_command(make_item(FUNC_TICK, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_TICK, 1'b0, MODE_UNLIMITED, 25'd0));
        wait_drained();
    endtask

    task automatic test_overcurrent();
        set_config(24'd0, 24'd0, 24'd1);
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'd1));
        send_command(make_item(FUNC_START, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'h1FFFFFF));
        send_command(make_item(FUNC_TICK, 1'b0, MODE_UNLIMITED, 25'd0));
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'h1000000));
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'h0FFFFFF));
        send_command(make_item(FUNC_CURRENT, 1'b0, MODE_UNLIMITED, 25'd0));
        wait_drained();
    endtask

    task automatic run_random(int count, int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_command(rand_item());
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> hold_go;
        repeat (40) send_command(rand_item());
        // hold the sender until every result is back, then resume
        wait_drained();
        repeat (20) send_command(rand_item());
        wait_drained();
    endtask

    initial begin
        shadow_cur_limit = CUR_LIMIT_RESET;
        shadow_oc_time   = OC_TIME_RESET;
        shadow_step      = STEP_RESET;
        motor_dir        = DIR_STOP;
        motor_timed      = 1'b0;
        motor_remain     = '0;
        motor_exc_on     = 1'b0;
        motor_exc_cnt    = '0;
        motor_switches   = SWITCH_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_moves();
        test_limit_switches();
        test_timed_expiry();
        test_overcurrent();

        set_config(24'($urandom_range(3000000)), 24'($urandom_range(8)),
                   24'($urandom_range(1, 60)));
        run_random(220, 0, 0);
        // all-ones writes clamp every register to its ceiling
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_random(200, 58, 0);
        set_config(24'd0, 24'd0, 24'd0);
        run_random(200, 0, 58);
        set_config(24'($urandom_range(10000000)), 24'($urandom_range(12)),
                   24'($urandom_range(1, 150)));
        run_random(200, 16, 16);
        set_config(24'($urandom_range(2000000)), 24'($urandom_range(4)),
                   24'($urandom_range(1, 20)));
        test_backpressure();

        repeat (8) @(posedge aclk);
        if (pending_status.size() != 0) begin
            $display("%0d expected results never arrived", pending_status.size());
            mismatch_cnt += pending_status.size();
        end
        $display("Covered %0d items and %0d results, %0d of them reporting a stop,",
                 items_sent, results_seen, stops_seen);
        $display("across idle, stall and hold-off patterns and several register settings.");
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
